// ----- design/assert_macros.svh -----
// Assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication check with async reset disable
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication check
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- design/aes_cbc_pkg.sv -----
// Package: AES constants, S-box functions and controller command/status types
`timescale 1ns / 1ps
package aes_cbc_pkg;

	localparam logic [2:0] IDX_KEY0 = 3'd0;
	localparam logic [2:0] IDX_KEY1 = 3'd1;
	localparam logic [2:0] IDX_KEY2 = 3'd2;
	localparam logic [2:0] IDX_KEY3 = 3'd3;
	localparam logic [2:0] IDX_IVU  = 3'd4;
	localparam logic [2:0] IDX_IVL  = 3'd5;
	localparam logic [2:0] IDX_KSZ  = 3'd6;
	localparam logic [2:0] IDX_DIR  = 3'd7;
	localparam logic [7:0] GF_POLY  = 8'h1b;

	// controller -> datapath commands
	typedef struct packed {
		logic       exp_start;  // load key schedule registers
		logic       exp_step;   // produce one expanded key word
		logic       blk_load;   // capture input word, apply first round key
		logic       rnd_step;   // run one round
		logic       rnd_last;   // this round skips the mix step
		logic       out_load;   // write result register and chaining value
		logic [3:0] rk_addr;    // round key read address (round index)
	} dp_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic exp_done;
		logic [3:0] nr;
	} dp_stat_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[a];
	endfunction

	// forward mix of one column (rows 0..3 in bytes 31:24 .. 7:0)
	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	// inverse mix: premultiply by {5,0,4,0}-style reduction then forward mix
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, u, v;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		u = xtime(xtime(a0 ^ a2));
		v = xtime(xtime(a1 ^ a3));
		inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

// ----- design/aes_cbc_ctrl.sv -----
// Controller: sequences key expansion, rounds and result handoff
`timescale 1ns / 1ps
module aes_cbc_ctrl
	import aes_cbc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  logic     dir,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXPINI = 3'd1;
	localparam logic [2:0] ST_EXPAND = 3'd2;
	localparam logic [2:0] ST_LOAD   = 3'd3;
	localparam logic [2:0] ST_ROUND  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0] state_q;
	logic       keys_ready_q;
	logic [3:0] rnd_q;
	logic [3:0] rnd_nx;
	logic       ov_q;
	logic       take;

	// input taken only in the load state (keys valid) and with the result slot free or leaving
	assign take     = (state_q == ST_LOAD) && in_valid && (!ov_q || !out_stall);
	assign in_stall = !take;
	assign out_valid = ov_q;
	assign rnd_nx   = rnd_q + 4'd1;

	// round 0 is the initial key add; key for round rnd_q+1 is fetched ahead
	always_comb begin
		cmd = '0;
		cmd.exp_start = (state_q == ST_EXPINI);
		cmd.exp_step  = (state_q == ST_EXPAND);
		cmd.blk_load  = take;
		cmd.rnd_step  = (state_q == ST_ROUND) && (rnd_q != 4'd0);
		cmd.rnd_last  = (state_q == ST_ROUND) && (rnd_q == stat.nr);
		cmd.out_load  = (state_q == ST_DONE) && (!ov_q || !out_stall);
		if (state_q == ST_LOAD)
			cmd.rk_addr = dir ? stat.nr : 4'd0;
		else if (state_q == ST_ROUND && rnd_q < stat.nr)
			cmd.rk_addr = dir ? stat.nr - rnd_nx : rnd_nx;
		else
			cmd.rk_addr = 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			keys_ready_q <= 1'b0;
			rnd_q        <= '0;
			ov_q         <= 1'b0;
		end else begin
			// result slot: filled from the done state, emptied when taken
			if (cmd.out_load)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;
			// any register write invalidates the round key store
			if (cfg_we)
				keys_ready_q <= 1'b0;
			else if (state_q == ST_EXPAND && stat.exp_done)
				keys_ready_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !cfg_we)
						state_q <= keys_ready_q ? ST_LOAD : ST_EXPINI;
				end
				ST_EXPINI: state_q <= ST_EXPAND;
				ST_EXPAND: begin
					if (stat.exp_done)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (take) begin
						rnd_q   <= 4'd0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_nx;
					if (rnd_q == stat.nr)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/aes_cbc_dp.sv -----
// Datapath: config registers, key schedule, round key store, round unit, chaining
`timescale 1ns / 1ps
module aes_cbc_dp
	import aes_cbc_pkg::*;
#(
	parameter int CHAIN_CBC  = 1,
	parameter int MAX_ROUNDS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [63:0] block_upper,
	input  logic [63:0] block_lower,
	input  logic        start_of_message,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic        dir,
	output logic [63:0] out_upper,
	output logic [63:0] out_lower
);

	logic [63:0] key_q [4];
	logic [127:0] iv_q;
	logic [1:0] ksz_q;
	logic       dir_q;
	logic [127:0] chain_q;
	logic [127:0] st_q;
	logic [127:0] blk_q;
	logic [127:0] res_q;
	logic [127:0] rk_mem [MAX_ROUNDS + 1];
	logic [127:0] rk;

	// effective key length
	logic [1:0] ks_eff;
	logic [3:0] nk, nr;
	always_comb begin
		ks_eff = (ksz_q == 2'd3) ? 2'd2 : ksz_q;
		if (ks_eff == 2'd2 && MAX_ROUNDS < 14) ks_eff = 2'd1;
		if (ks_eff == 2'd1 && MAX_ROUNDS < 12) ks_eff = 2'd0;
		nk = 4'd4 + {1'b0, ks_eff, 1'b0};
		nr = nk + 4'd6;
	end
	assign stat.nr = nr;
	assign dir = dir_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			iv_q  <= '0;
			ksz_q <= '0;
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				IDX_KEY0: key_q[0] <= cfg_data;
				IDX_KEY1: key_q[1] <= cfg_data;
				IDX_KEY2: key_q[2] <= cfg_data;
				IDX_KEY3: key_q[3] <= cfg_data;
				IDX_IVU:  iv_q[127:64] <= cfg_data;
				IDX_IVL:  iv_q[63:0] <= cfg_data;
				IDX_KSZ:  ksz_q <= cfg_data[1:0];
				IDX_DIR:  dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key schedule: 8-word window, one new word per step, 4 words packed per row
	logic [31:0] win_q [8];
	logic [5:0]  wi_q;     // index of the word being produced
	logic [2:0]  ph_q;     // wi mod nk
	logic [7:0]  rcon_q;
	logic [127:0] row_q;
	logic        exp_done_q;
	logic [31:0] t, neww;

	always_comb begin
		t = win_q[3'(nk - 4'd1)];
		if (ph_q == 3'd0)
			t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h0};
		else if (nk == 4'd8 && ph_q == 3'd4)
			t = sub_word(t);
		neww = win_q[0] ^ t;
	end
	assign stat.exp_done = exp_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q       <= '0;
			ph_q       <= '0;
			rcon_q     <= 8'h01;
			exp_done_q <= 1'b0;
		end else if (cmd.exp_start) begin
			wi_q       <= {2'b0, nk};
			ph_q       <= '0;
			rcon_q     <= 8'h01;
			exp_done_q <= 1'b0;
		end else if (cmd.exp_step && !exp_done_q) begin
			wi_q   <= wi_q + 6'd1;
			ph_q   <= (ph_q + 3'd1 == nk[2:0] || nk == 4'd8 && ph_q == 3'd7) ? 3'd0
				: ph_q + 3'd1;
			if (ph_q == 3'd0) rcon_q <= xtime(rcon_q);
			if (wi_q + 6'd1 == 6'(4 * ({2'b0, nr} + 6'd1))) exp_done_q <= 1'b1;
		end
	end

	// window shift and packing of finished words into rows
	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			win_q[0] <= key_q[0][63:32]; win_q[1] <= key_q[0][31:0];
			win_q[2] <= key_q[1][63:32]; win_q[3] <= key_q[1][31:0];
			win_q[4] <= key_q[2][63:32]; win_q[5] <= key_q[2][31:0];
			win_q[6] <= key_q[3][63:32]; win_q[7] <= key_q[3][31:0];
			// row buffer starts with the last four key words
			row_q <= (nk == 4'd4) ? {key_q[0], key_q[1]}
				: (nk == 4'd6) ? {key_q[1], key_q[2]} : {key_q[2], key_q[3]};
		end else if (cmd.exp_step && !exp_done_q) begin
			for (int i = 0; i < 7; i++)
				win_q[i] <= (4'(i) == nk - 4'd1) ? neww
					: (4'(i) < nk - 4'd1) ? win_q[i + 1] : win_q[i];
			win_q[7] <= (nk == 4'd8) ? neww : win_q[7];
			row_q <= {row_q[95:0], neww};
		end
	end

	// round key memory: key words enter in order, a row is written every fourth
	logic [5:0] wcnt;
	logic [31:0] wd;
	logic [127:0] wrow;
	logic        wen;
	logic [3:0]  waddr;
	always_comb begin
		wen = 1'b0; wrow = '0; waddr = '0; wd = '0; wcnt = '0;
		if (cmd.exp_start) begin
			wen = 1'b1; waddr = 4'd0; wrow = {key_q[0], key_q[1]};
		end else if (cmd.exp_step && !exp_done_q) begin
			wcnt = wi_q + 6'd1;
			wd = neww;
			if (wcnt[1:0] == 2'b00) begin
				wen = 1'b1;
				waddr = 4'(wi_q[5:2]);
				wrow = {row_q[95:0], wd};
			end
		end
		// 256-bit key: second row is key words 4..7 written at first step
	end

	logic [127:0] row1;
	assign row1 = {key_q[2], key_q[3]};
	logic row1_pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) row1_pend_q <= 1'b0;
		else row1_pend_q <= cmd.exp_start && nk == 4'd8;
	end

	always_ff @(posedge clk) begin
		if (wen) rk_mem[waddr] <= wrow;
		else if (row1_pend_q) rk_mem[1] <= row1;
		rk <= rk_mem[cmd.rk_addr];
	end

	// round function
	logic [127:0] sb, sr, mx, din, rs, rin;
	logic [127:0] ch;
	assign ch = (CHAIN_CBC != 0) ? (start_of_message ? iv_q : chain_q) : '0;
	always_comb begin
		for (int i = 0; i < 16; i++)
			sb[127 - 8*i -: 8] = dir_q ? inv_sbox(st_q[127 - 8*i -: 8])
				: sbox(st_q[127 - 8*i -: 8]);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				sr[127 - 8*(4*c + r) -: 8] =
					sb[127 - 8*(4*((dir_q ? c - r + 4 : c + r) & 3) + r) -: 8];
		for (int c = 0; c < 4; c++) begin
			if (dir_q) mx[127 - 32*c -: 32] = inv_mix_col(sr[127 - 32*c -: 32] ^ rk[127 - 32*c -: 32]);
			else mx[127 - 32*c -: 32] = mix_col(sr[127 - 32*c -: 32]);
		end
		if (cmd.rnd_last) rs = sr ^ rk;
		else if (dir_q) rs = mx;
		else rs = mx ^ rk;
	end

	// input word registered in the cycle before the first key add
	logic ld_s1;
	logic [127:0] ch_s1;
	assign din = {block_upper, block_lower};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ld_s1 <= 1'b0;
		else ld_s1 <= cmd.blk_load;
	end

	always_ff @(posedge clk) begin
		if (cmd.blk_load) begin
			blk_q <= din;
			ch_s1 <= ch;
		end
	end
	assign rin = dir_q ? blk_q : (blk_q ^ ch_s1);

	// state register: first key add in the cycle after capture
	always_ff @(posedge clk) begin
		if (ld_s1) st_q <= rin ^ rk;
		else if (cmd.rnd_step) st_q <= rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chain_q <= '0;
		else if (cmd.out_load && CHAIN_CBC != 0)
			chain_q <= dir_q ? blk_q : st_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) res_q <= dir_q ? (st_q ^ ch_s1) : st_q;
	end
	assign out_upper = res_q[127:64];
	assign out_lower = res_q[63:0];

endmodule

// ----- design/aes_block_cipher_cbc_core.sv -----
// AES-128/192/256 CBC block engine (chaining off when CHAIN_CBC is 0)
// Usage: write key, IV, key size and direction through the write port while
// idle (no input word accepted whose result is not yet taken). Then present
// 128-bit words as block_upper/block_lower with in_valid; start_of_message
// reloads the chaining value from the IV. One result word comes out per
// input word on out_valid.
// After a configuration write the first word waits for the key expansion:
// one setup step, then one key word per cycle. An accepted word gets the
// initial key add, one step per round (10, 12 or 14 rounds) and a write
// into the result register. The controller passes through its idle and load
// states between words, and the single shared round unit serves one word at
// a time, so a new word is accepted only after the last result is written.
// The result register holds its word while out_stall is high; a new word is
// accepted only once that slot is free or being drained.
// Reset clears control, chaining value and configuration; round keys are
// rebuilt before the first word.
`timescale 1ns / 1ps
module aes_block_cipher_cbc_core
	import aes_cbc_pkg::*;
#(
	parameter int CHAIN_CBC  = 1,
	parameter int MAX_ROUNDS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_upper,
	input  logic [63:0] block_lower,
	input  logic        start_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_upper,
	output logic [63:0] out_lower
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     dir;

	aes_cbc_ctrl u_ctrl (
		.clk, .arst_n, .cfg_we, .in_valid, .in_stall, .out_valid, .out_stall,
		.dir, .stat, .cmd
	);

	aes_cbc_dp #(.CHAIN_CBC(CHAIN_CBC), .MAX_ROUNDS(MAX_ROUNDS)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .block_upper, .block_lower,
		.start_of_message, .cmd, .stat, .dir, .out_upper, .out_lower
	);

endmodule

// ----- design/aes_cbc_checker.sv -----
// Port-level checker for the AES CBC core, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_cbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] out_upper
);
	// a stalled result word stays valid and its upper half stays put
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_data, clk, arst_n, out_valid && out_stall, $stable(out_upper))
	// no accept in the cycle right after an accept (rounds in progress)
	`ASSERT_NEXT(a_no_b2b, clk, arst_n, in_valid && !in_stall, in_stall)
	// no result appears the cycle after an accept made while no result was pending
	`ASSERT_NEXT(a_lat, clk, arst_n, in_valid && !in_stall && !out_valid, !out_valid)
endmodule

bind aes_block_cipher_cbc_core aes_cbc_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_upper
);
